// ===== sv/ums_pkg.sv =====
// shared constants, types and tables of the unix millisecond to calendar date converter
`timescale 1ns / 1ps

package ums_pkg;

   // pipeline layout: day split, then date and time of day side by side
   localparam int DAYS_STAGES = 4;
   localparam int DATE_STAGES = 6;
   localparam int STAGES      = DAYS_STAGES + DATE_STAGES;

   typedef logic [STAGES-1:0] ums_stage_type;

   // widths of values passed between the pipeline parts
   localparam int MS_W   = 48;
   localparam int DAYS_W = 22;
   localparam int REM_W  = 27;

   // milliseconds per day over 1024, and its reciprocals for the two chunk divides
   localparam logic [16:0] DAY_DIV     = 17'd84375;
   localparam logic [24:0] DAY_RCP_HI  = 25'(((64'd1 << 41) + 64'd84374) / 64'd84375);
   localparam logic [31:0] DAY_RCP_LO  = 32'(((64'd1 << 48) + 64'd84374) / 64'd84375);

   // time of day: ms over 8 by 125, seconds by 60 and by 3600
   localparam logic [24:0] SEC_RCP     = 25'(((64'd1 << 31) + 64'd124) / 64'd125);
   localparam logic [17:0] MIN_RCP     = 18'(((64'd1 << 23) + 64'd59) / 64'd60);
   localparam logic [17:0] HOUR_RCP    = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
   localparam logic [6:0]  SIXTY       = 7'd60;

   // gregorian century correction
   localparam logic [23:0] CENT_OFFSET = 24'd102032;
   localparam logic [24:0] GC_RCP      = 25'(((64'd1 << 42) + 64'd146096) / 64'd146097);
   localparam logic [6:0]  GC_BIAS     = 7'd15;

   // day number and march based year
   localparam logic [22:0] JD_OFFSET   = 23'd2442113;
   localparam logic [26:0] YEAR_OFFSET = 27'd2442;
   localparam logic [27:0] YR_RCP      = 28'(((64'd1 << 40) + 64'd7304) / 64'd7305);
   localparam logic [22:0] DAYS_YEAR   = 23'd365;

   // month from day of year: doy * 1000 / 30601 folded into one constant
   localparam logic [29:0] MO_RCP      = 30'(64'd1000 * (((64'd1 << 34) + 64'd30600) / 64'd30601));

   // fold of march based months back to the calendar year
   localparam logic [4:0]  LAST_SHIFTED_MONTH = 5'd13;
   localparam logic [4:0]  MONTH_BASE_LO      = 5'd1;
   localparam logic [4:0]  MONTH_BASE_HI      = 5'd13;
   localparam logic [13:0] YEAR_BASE_LO       = 14'd4716;
   localparam logic [13:0] YEAR_BASE_HI       = 14'd4715;

   // days before the start of a march based month: mo * 30 + mo * 601 / 1000
   function automatic logic [8:0] ums_month_start(input logic [4:0] mo);
      logic [8:0] start;
      unique case (mo)
         5'd0:    start = 9'd0;
         5'd1:    start = 9'd30;
         5'd2:    start = 9'd61;
         5'd3:    start = 9'd91;
         5'd4:    start = 9'd122;
         5'd5:    start = 9'd153;
         5'd6:    start = 9'd183;
         5'd7:    start = 9'd214;
         5'd8:    start = 9'd244;
         5'd9:    start = 9'd275;
         5'd10:   start = 9'd306;
         5'd11:   start = 9'd336;
         5'd12:   start = 9'd367;
         5'd13:   start = 9'd397;
         5'd14:   start = 9'd428;
         5'd15:   start = 9'd459;
         5'd16:   start = 9'd489;
         default: start = 9'd0;
      endcase
      return start;
   endfunction

endpackage

// ===== sv/ums_ifs.sv =====
// valid/ready channel interfaces for the timestamp and the calendar result
`timescale 1ns / 1ps

interface ums_req_if;
   logic        valid;
   logic        ready;
   logic [47:0] unix_ms;

   modport source (output valid, output unix_ms, input ready);
   modport sink   (input valid, input unix_ms, output ready);
endinterface

interface ums_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  second;
   logic [5:0]  minute;
   logic [4:0]  hour;
   logic [4:0]  day_of_month;
   logic [3:0]  month;
   logic [13:0] year;

   modport source (output valid, output second, output minute, output hour,
                   output day_of_month, output month, output year, input ready);
   modport sink   (input valid, input second, input minute, input hour,
                   input day_of_month, input month, input year, output ready);
endinterface

// ===== sv/ums_days.sv =====
// splits a millisecond timestamp into whole days and milliseconds of the day
`timescale 1ns / 1ps

module ums_days import ums_pkg::*; (
   input  logic                   clock,
   input  logic [DAYS_STAGES-1:0] en,
   input  logic [MS_W-1:0]        unix_ms,
   output logic [DAYS_W-1:0]      days,
   output logic [REM_W-1:0]       rem_ms
);

   // the low 10 bits ride along; (ms >> 10) / 84375 is done as two chunk divides
   logic [48:0] p1;
   logic [7:0]  q1_in, q1_ff, q1b_ff, q1c_ff;
   logic [23:0] n1_ff, lo_ff, lob_ff;
   logic [24:0] q1d, r1_full;
   logic [16:0] r1_in, r1_ff;
   logic [30:0] n2_in, n2_ff, q2d, r2_full;
   logic [62:0] p2;
   logic [13:0] q2_in, q2_ff;
   logic [9:0]  msl_ff;
   logic [DAYS_W-1:0] days_in, days_ff;
   logic [REM_W-1:0]  rem_in, rem_ff;

   // stage 0: high chunk quotient by reciprocal
   assign p1    = unix_ms[47:24] * DAY_RCP_HI;
   assign q1_in = p1[48:41];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         q1_ff <= q1_in;
         n1_ff <= unix_ms[47:24];
         lo_ff <= unix_ms[23:0];
      end
   end

   // stage 1: high chunk remainder
   assign q1d     = q1_ff * DAY_DIV;
   assign r1_full = {1'b0, n1_ff} - q1d;
   assign r1_in   = r1_full[16:0];

   always_ff @(posedge clock) begin
      if (en[1]) begin
         r1_ff  <= r1_in;
         q1b_ff <= q1_ff;
         lob_ff <= lo_ff;
      end
   end

   // stage 2: low chunk quotient, remainder joined with the next 14 bits
   assign n2_in = {r1_ff, lob_ff[23:10]};
   assign p2    = n2_in * DAY_RCP_LO;
   assign q2_in = p2[61:48];

   always_ff @(posedge clock) begin
      if (en[2]) begin
         q2_ff  <= q2_in;
         n2_ff  <= n2_in;
         q1c_ff <= q1b_ff;
         msl_ff <= lob_ff[9:0];
      end
   end

   // stage 3: low chunk remainder gives the milliseconds of the day
   assign q2d     = q2_ff * DAY_DIV;
   assign r2_full = n2_ff - q2d;
   assign days_in = {q1c_ff, q2_ff};
   assign rem_in  = {r2_full[16:0], msl_ff};

   always_ff @(posedge clock) begin
      if (en[3]) begin
         days_ff <= days_in;
         rem_ff  <= rem_in;
      end
   end

   assign days   = days_ff;
   assign rem_ms = rem_ff;

endmodule

// ===== sv/ums_tod.sv =====
// hour, minute and second from the milliseconds of the day
`timescale 1ns / 1ps

module ums_tod import ums_pkg::*; (
   input  logic                   clock,
   input  logic [DATE_STAGES-1:0] en,
   input  logic [REM_W-1:0]       rem_ms,
   output logic [5:0]             second,
   output logic [5:0]             minute,
   output logic [4:0]             hour
);

   typedef struct packed {
      logic [5:0] second;
      logic [5:0] minute;
      logic [4:0] hour;
   } ums_tod_type;

   logic [48:0] ps;
   logic [16:0] sod_in, sod_ff, sodb_ff;
   logic [34:0] p60, p3600;
   logic [10:0] q60_in, q60_ff;
   logic [4:0]  hr_in, hr_ff;
   logic [16:0] sec_full;
   logic [10:0] min_full;
   ums_tod_type tod_in, tod6_ff, tod7_ff, tod8_ff, tod9_ff;

   // seconds of the day: (ms >> 3) / 125
   assign ps     = rem_ms[26:3] * SEC_RCP;
   assign sod_in = ps[47:31];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         sod_ff <= sod_in;
      end
   end

   // minutes of the day and hour, both straight from the seconds
   assign p60    = sod_ff * MIN_RCP;
   assign p3600  = sod_ff * HOUR_RCP;
   assign q60_in = p60[33:23];
   assign hr_in  = p3600[33:29];

   always_ff @(posedge clock) begin
      if (en[1]) begin
         q60_ff  <= q60_in;
         hr_ff   <= hr_in;
         sodb_ff <= sod_ff;
      end
   end

   // remainders give second and minute
   assign sec_full      = sodb_ff - q60_ff * SIXTY;
   assign min_full      = q60_ff - hr_ff * SIXTY;
   assign tod_in.second = sec_full[5:0];
   assign tod_in.minute = min_full[5:0];
   assign tod_in.hour   = hr_ff;

   // result waits for the date side
   always_ff @(posedge clock) begin
      if (en[2]) begin
         tod6_ff <= tod_in;
      end
      if (en[3]) begin
         tod7_ff <= tod6_ff;
      end
      if (en[4]) begin
         tod8_ff <= tod7_ff;
      end
      if (en[5]) begin
         tod9_ff <= tod8_ff;
      end
   end

   assign second = tod9_ff.second;
   assign minute = tod9_ff.minute;
   assign hour   = tod9_ff.hour;

endmodule

// ===== sv/ums_civil.sv =====
// gregorian year, month and day of month from the day count since 1970
`timescale 1ns / 1ps

module ums_civil import ums_pkg::*; (
   input  logic                   clock,
   input  logic [DATE_STAGES-1:0] en,
   input  logic [DAYS_W-1:0]      days,
   output logic [4:0]             day_of_month,
   output logic [3:0]             month,
   output logic [13:0]            year
);

   logic [23:0] ngc;
   logic [48:0] pgc;
   logic [6:0]  gcq_in, gcq_ff, gc;
   logic [DAYS_W-1:0] t_ff;
   logic [22:0] b_in, b5_ff, b6_ff;
   logic [26:0] nyr_in, nyr_ff;
   logic [54:0] pyr;
   logic [13:0] yr_in, yr6_ff, yr7_ff, yr8_ff;
   logic [22:0] doy_full;
   logic [8:0]  doy_in, doy7_ff, doy8_ff;
   logic [38:0] pmo;
   logic [4:0]  mo_in, mo8_ff;
   logic [8:0]  dom_full;
   logic [4:0]  month_full;
   logic [4:0]  dom_in, dom_ff;
   logic [3:0]  month_in, month_ff;
   logic [13:0] year_in, year_ff;

   // stage 4: century count (4t + offset) / 146097
   assign ngc    = {days, 2'b00} + CENT_OFFSET;
   assign pgc    = ngc * GC_RCP;
   assign gcq_in = pgc[48:42];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         gcq_ff <= gcq_in;
         t_ff   <= days;
      end
   end

   // stage 5: day number with gregorian correction, and 20b - offset
   assign gc     = gcq_ff + GC_BIAS;
   assign b_in   = 23'(t_ff) + JD_OFFSET + 23'(gc) - 23'(gc[6:2]);
   assign nyr_in = {b_in, 4'b0000} + {2'b00, b_in, 2'b00} - YEAR_OFFSET;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         b5_ff  <= b_in;
         nyr_ff <= nyr_in;
      end
   end

   // stage 6: march based year
   assign pyr   = nyr_ff * YR_RCP;
   assign yr_in = pyr[53:40];

   always_ff @(posedge clock) begin
      if (en[2]) begin
         yr6_ff <= yr_in;
         b6_ff  <= b5_ff;
      end
   end

   // stage 7: day within the march based year
   assign doy_full = b6_ff - 23'(yr6_ff) * DAYS_YEAR - 23'(yr6_ff[13:2]);
   assign doy_in   = doy_full[8:0];

   always_ff @(posedge clock) begin
      if (en[3]) begin
         doy7_ff <= doy_in;
         yr7_ff  <= yr6_ff;
      end
   end

   // stage 8: march based month
   assign pmo   = doy7_ff * MO_RCP;
   assign mo_in = pmo[38:34];

   always_ff @(posedge clock) begin
      if (en[4]) begin
         mo8_ff  <= mo_in;
         doy8_ff <= doy7_ff;
         yr8_ff  <= yr7_ff;
      end
   end

   // stage 9: day of month, and january/february move to the next year
   assign dom_full = doy8_ff - ums_month_start(mo8_ff);
   assign dom_in   = dom_full[4:0];

   always_comb begin
      if (mo8_ff <= LAST_SHIFTED_MONTH) begin
         year_in    = yr8_ff - YEAR_BASE_LO;
         month_full = mo8_ff - MONTH_BASE_LO;
      end else begin
         year_in    = yr8_ff - YEAR_BASE_HI;
         month_full = mo8_ff - MONTH_BASE_HI;
      end
   end

   assign month_in = month_full[3:0];

   always_ff @(posedge clock) begin
      if (en[5]) begin
         dom_ff   <= dom_in;
         month_ff <= month_in;
         year_ff  <= year_in;
      end
   end

   assign day_of_month = dom_ff;
   assign month        = month_ff;
   assign year         = year_ff;

endmodule

// ===== sv/unix_ms_to_datetime.sv =====
// top level of the unix millisecond timestamp to calendar date and time converter
`timescale 1ns / 1ps

// Converts a 48-bit count of milliseconds since 1970-01-01 00:00:00 into second, minute,
// hour, day of month, month and full Gregorian year. One timestamp can be taken on every
// clock while the result side does not stall. The ten stages come from the chain of
// constant divides done by reciprocal multiplies: a two-chunk divide of the timestamp by
// the length of a day (four stages), followed by six stages for the year, day-of-year and
// month formulas, with the time of day computed alongside. A stall on the result side
// holds a stage only when it and every stage after it hold a valid item; empty stages
// keep filling, so the input stays ready until every stage is full. The block keeps no
// state between timestamps and needs no warm-up after reset.
module unix_ms_to_datetime import ums_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ums_req_if.sink   req_ch,
   ums_rsp_if.source rsp_ch
);

   ums_stage_type     valid_ff, valid_in, stage_en;
   logic [DAYS_W-1:0] days;
   logic [REM_W-1:0]  rem_ms;

   // a stage moves when the output drains or some stage at or after it is empty
   always_comb begin
      for (int k = 0; k < STAGES; k++) begin
         stage_en[k] = rsp_ch.ready || !(&(valid_ff | ums_stage_type'((1 << k) - 1)));
      end
   end

   // valid bits travel with the data
   assign valid_in = (stage_en & {valid_ff[STAGES-2:0], req_ch.valid}) | (~stage_en & valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ch.ready = stage_en[0];
   assign rsp_ch.valid = valid_ff[STAGES-1];

   // day split
   ums_days u_days (
      .clock   (clock),
      .en      (stage_en[DAYS_STAGES-1:0]),
      .unix_ms (req_ch.unix_ms),
      .days    (days),
      .rem_ms  (rem_ms)
   );

   // time of day
   ums_tod u_tod (
      .clock  (clock),
      .en     (stage_en[STAGES-1:DAYS_STAGES]),
      .rem_ms (rem_ms),
      .second (rsp_ch.second),
      .minute (rsp_ch.minute),
      .hour   (rsp_ch.hour)
   );

   // calendar date
   ums_civil u_civil (
      .clock        (clock),
      .en           (stage_en[STAGES-1:DAYS_STAGES]),
      .days         (days),
      .day_of_month (rsp_ch.day_of_month),
      .month        (rsp_ch.month),
      .year         (rsp_ch.year)
   );

endmodule

// ===== sv/ums_chk.sv =====
// port level checks of the timestamp converter and their binding to the top level
`timescale 1ns / 1ps

module ums_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [5:0]  second,
   input logic [5:0]  minute,
   input logic [4:0]  hour,
   input logic [4:0]  day_of_month,
   input logic [3:0]  month,
   input logic [13:0] year
);

   // a stalled result holds until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({second, minute, hour, day_of_month, month, year}))
      else $error("result changed while stalled");

   // every result is a real date and time of day
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> second < 6'd60 && minute < 6'd60 && hour < 5'd24 &&
         day_of_month >= 5'd1 && month >= 4'd1 && month <= 4'd12 &&
         year >= 14'd1970 && year <= 14'd10889)
      else $error("result field out of range");

   // the input is never held off while the output side drains or is empty
   a_no_bubble_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_ready || !rsp_valid |-> req_ready)
      else $error("input stalled with a free pipeline");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind unix_ms_to_datetime ums_chk u_ums_chk (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .second       (rsp_ch.second),
   .minute       (rsp_ch.minute),
   .hour         (rsp_ch.hour),
   .day_of_month (rsp_ch.day_of_month),
   .month        (rsp_ch.month),
   .year         (rsp_ch.year)
);
